// ===== src/ctt_pkg.sv =====
// shared types and constants for the config text tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package ctt_pkg;

  localparam int TOKEN_LEN_W     = 7;
  localparam int MAX_TOKEN_LEN_D = 64;
  localparam int QUEUE_DEPTH_D   = 4;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef enum logic [2:0] {
    K_SYMBOL = 3'd0,
    K_CHAR   = 3'd1,
    K_STRING = 3'd2,
    K_WORD   = 3'd3,
    K_END    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_CHAR   = 2'd1,
    ERR_LONG   = 2'd2,
    ERR_STRING = 2'd3
  } err_t;

  // byte classes, found once in the front
  typedef struct packed {
    logic space;    // space, tab, cr, lf
    logic newline;  // cr or lf
    logic hash;
    logic symbol;
    logic squote;
    logic dquote;
    logic bslash;
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic       eot;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
    err_t       err;
  } res_t;

endpackage

`default_nettype wire

// ===== src/config_text_tokenizer_core.sv =====
// config text tokenizer: top level joining front, queue and back
// depends on ctt_pkg, ctt_front, ctt_queue, ctt_back
`default_nettype none

// Streams text one byte per transfer on s_axis (tlast marks end of text, tdata
// is ignored on that transfer) and gives one token character per transfer on
// m_axis, with the token kind in tuser, tlast on the final character of each
// token and an error code beside the character. Spaces, tabs, CR, LF and #
// comments are skipped; symbols { } : ; + = , are one-character tokens;
// quoted char literals and strings come with their quotes and with escapes
// removed; bare words end at any delimiter. An error closes the token with
// tlast and its code, and scanning resumes between tokens. End of text
// flushes any open token and then gives an end token of kind 4. The block
// takes one byte per cycle while the result port accepts and no second result
// waits in the spare slot: a byte that ends a word and also opens a symbol or
// quote, a word byte that reaches the length limit, or an end of text that
// closes a token makes two results and holds off the next byte until the
// second has moved to the output register. A byte passes through the classify
// register, the queue and the output register before its first result appears.

module config_text_tokenizer_core #(
  parameter int MAX_TOKEN_LEN = ctt_pkg::MAX_TOKEN_LEN_D,
  parameter int QUEUE_DEPTH   = ctt_pkg::QUEUE_DEPTH_D
) (
  input  wire  logic       clk,
  input  wire  logic       rst,
  // input text stream
  input  wire  logic       s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  wire  logic       s_axis_tlast,   // end_of_text
  // token stream
  output logic             m_axis_tvalid,
  input  wire  logic       m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] token_char, [9:8] error_code, rest zero
  output logic [2:0]       m_axis_tuser,   // [2:0] token_kind
  output logic             m_axis_tlast    // token_last
);
  import ctt_pkg::*;

  // classified byte from front to queue
  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;

  // queue to scanner
  logic  qb_valid;
  logic  qb_ready;
  item_t qb_item;

  // scanner result register
  res_t  out_res;

  // front: register and classify each byte
  ctt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_eot   (s_axis_tlast),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  // decouples the front from stalls in the scanner
  ctt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // back: token state machine, up to two results per byte
  ctt_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (qb_valid),
    .in_ready  (qb_ready),
    .in_item   (qb_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // pack result fields onto the stream
  assign m_axis_tdata = {6'b0, out_res.err, out_res.ch};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== src/ctt_front.sv =====
// front stage: takes text bytes and classifies them into queue items
// depends on ctt_pkg
`default_nettype none

module ctt_front (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  wire                logic [7:0] in_data,
  input  wire                logic in_eot,
  output logic               q_valid,
  input  wire                logic q_ready,
  output ctt_pkg::item_t     q_item
);
  import ctt_pkg::*;

  logic  valid;
  item_t item;

  function automatic item_t classify(input logic [7:0] b, input logic eot);
    item_t it;
    it.data       = b;
    it.eot        = eot;
    it.cls.newline = (b == CH_LF) || (b == CH_CR);
    it.cls.space  = (b == CH_SPACE) || (b == CH_TAB) || it.cls.newline;
    it.cls.hash   = (b == CH_HASH);
    it.cls.symbol = (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_COLON) ||
                    (b == CH_SEMI) || (b == CH_PLUS) || (b == CH_EQUAL) ||
                    (b == CH_COMMA);
    it.cls.squote = (b == CH_SQUOTE);
    it.cls.dquote = (b == CH_DQUOTE);
    it.cls.bslash = (b == CH_BSLASH);
    return it;
  endfunction

  assign in_ready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (q_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= classify(in_data, in_eot);
    end
  end

endmodule

`default_nettype wire

// ===== src/ctt_queue.sv =====
// short queue of classified items between front and back
// depends on ctt_pkg
`default_nettype none

module ctt_queue #(
  parameter int DEPTH = ctt_pkg::QUEUE_DEPTH_D
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic push_valid,
  output logic               push_ready,
  input  ctt_pkg::item_t     push_item,
  output logic               pop_valid,
  input  wire                logic pop_ready,
  output ctt_pkg::item_t     pop_item
);
  import ctt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("full queue with unequal pointers");

endmodule

`default_nettype wire

// ===== src/ctt_back.sv =====
// back stage: scanner state machine and result output register
// depends on ctt_pkg
`default_nettype none

module ctt_back #(
  parameter int MAX_TOKEN_LEN = ctt_pkg::MAX_TOKEN_LEN_D
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  ctt_pkg::item_t     in_item,
  output logic               out_valid,
  input  wire                logic out_ready,
  output ctt_pkg::res_t      out_res
);
  import ctt_pkg::*;

  localparam logic [TOKEN_LEN_W-1:0] MAX_LEN = TOKEN_LEN_W'(MAX_TOKEN_LEN);

  typedef enum logic [7:0] {
    M_IDLE       = 8'b0000_0001,
    M_COMMENT    = 8'b0000_0010,
    M_CHAR_OPEN  = 8'b0000_0100,
    M_CHAR_ESC   = 8'b0000_1000,
    M_CHAR_CLOSE = 8'b0001_0000,
    M_STRING     = 8'b0010_0000,
    M_STRING_ESC = 8'b0100_0000,
    M_WORD       = 8'b1000_0000
  } mode_t;

  mode_t                  mode, mode_next;
  logic [7:0]             held_char, held_char_next;
  logic                   held_valid, held_valid_next;
  logic [TOKEN_LEN_W-1:0] token_length, token_length_next;

  res_t                   pend;
  logic                   pend_valid;

  res_t                   res [2];
  logic [1:0]             cnt;

  // outcome of a byte seen between tokens
  logic                   st_v;
  res_t                   st_r;
  mode_t                  st_mode;
  logic [TOKEN_LEN_W-1:0] st_len;
  logic                   st_held_v;

  logic [TOKEN_LEN_W-1:0] len_inc;
  logic                   len_full;
  logic                   out_free;
  logic                   take;
  logic [7:0]             b;
  cls_t                   c;

  function automatic res_t mk(input kind_t k, input logic [7:0] ch,
                              input logic last, input err_t e);
    res_t r;
    r.kind = k;
    r.ch   = ch;
    r.last = last;
    r.err  = e;
    return r;
  endfunction

  assign b        = in_item.data;
  assign c        = in_item.cls;
  assign len_inc  = token_length + TOKEN_LEN_W'(1);
  assign len_full = (len_inc >= MAX_LEN);
  assign out_free = !out_valid || out_ready;
  assign in_ready = !pend_valid && out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    st_v      = 1'b0;
    st_r      = mk(K_SYMBOL, b, 1'b1, ERR_NONE);
    st_mode   = M_IDLE;
    st_len    = '0;
    st_held_v = 1'b0;
    priority if (c.space) begin
      st_mode = M_IDLE;
    end else if (c.hash) begin
      st_mode = M_COMMENT;
    end else if (c.symbol) begin
      st_v = 1'b1;
    end else if (c.squote) begin
      st_v    = 1'b1;
      st_r    = mk(K_CHAR, CH_SQUOTE, 1'b0, ERR_NONE);
      st_mode = M_CHAR_OPEN;
    end else if (c.dquote) begin
      st_v    = 1'b1;
      st_r    = mk(K_STRING, CH_DQUOTE, 1'b0, ERR_NONE);
      st_len  = TOKEN_LEN_W'(1);
      st_mode = M_STRING;
    end else begin
      st_held_v = 1'b1;
      st_len    = TOKEN_LEN_W'(1);
      st_mode   = M_WORD;
    end
  end

  always_comb begin
    mode_next         = mode;
    held_char_next    = held_char;
    held_valid_next   = held_valid;
    token_length_next = token_length;
    res[0]            = '0;
    res[1]            = '0;
    cnt               = '0;

    if (in_item.eot) begin
      unique case (mode)
        M_WORD: begin
          if (held_valid) begin
            res[cnt[0]] = mk(K_WORD, held_char, 1'b1, ERR_NONE);
            cnt = cnt + 2'd1;
          end
        end
        M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: begin
          res[cnt[0]] = mk(K_CHAR, 8'd0, 1'b1, ERR_CHAR);
          cnt = cnt + 2'd1;
        end
        M_STRING, M_STRING_ESC: begin
          res[cnt[0]] = mk(K_STRING, 8'd0, 1'b1, ERR_STRING);
          cnt = cnt + 2'd1;
        end
        default: begin
        end
      endcase
      res[cnt[0]] = mk(K_END, 8'd0, 1'b1, ERR_NONE);
      cnt = cnt + 2'd1;
      mode_next         = M_IDLE;
      held_char_next    = '0;
      held_valid_next   = 1'b0;
      token_length_next = '0;
    end else begin
      unique case (mode)
        M_IDLE: begin
          if (st_v) begin
            res[cnt[0]] = st_r;
            cnt = cnt + 2'd1;
          end
          mode_next         = st_mode;
          token_length_next = st_len;
          held_valid_next   = st_held_v;
          held_char_next    = st_held_v ? b : 8'd0;
        end
        M_COMMENT: begin
          if (c.newline) begin
            mode_next = M_IDLE;
          end
        end
        M_CHAR_OPEN: begin
          if (c.bslash) begin
            mode_next = M_CHAR_ESC;
          end else begin
            res[cnt[0]] = mk(K_CHAR, b, 1'b0, ERR_NONE);
            cnt = cnt + 2'd1;
            mode_next = M_CHAR_CLOSE;
          end
        end
        M_CHAR_ESC: begin
          res[cnt[0]] = mk(K_CHAR, b, 1'b0, ERR_NONE);
          cnt = cnt + 2'd1;
          mode_next = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          if (c.squote) begin
            res[cnt[0]] = mk(K_CHAR, CH_SQUOTE, 1'b1, ERR_NONE);
          end else begin
            res[cnt[0]] = mk(K_CHAR, b, 1'b1, ERR_CHAR);
          end
          cnt = cnt + 2'd1;
          mode_next         = M_IDLE;
          held_char_next    = '0;
          held_valid_next   = 1'b0;
          token_length_next = '0;
        end
        M_STRING, M_STRING_ESC: begin
          if (mode == M_STRING && c.dquote) begin
            res[cnt[0]] = mk(K_STRING, CH_DQUOTE, 1'b1, ERR_NONE);
            cnt = cnt + 2'd1;
            mode_next         = M_IDLE;
            held_char_next    = '0;
            held_valid_next   = 1'b0;
            token_length_next = '0;
          end else if (mode == M_STRING && c.bslash) begin
            mode_next = M_STRING_ESC;
          end else if (len_full) begin
            res[cnt[0]] = mk(K_STRING, b, 1'b1, ERR_LONG);
            cnt = cnt + 2'd1;
            mode_next         = M_IDLE;
            held_char_next    = '0;
            held_valid_next   = 1'b0;
            token_length_next = '0;
          end else begin
            res[cnt[0]] = mk(K_STRING, b, 1'b0, ERR_NONE);
            cnt = cnt + 2'd1;
            token_length_next = len_inc;
            mode_next = M_STRING;
          end
        end
        M_WORD: begin
          if (c.space || c.symbol || c.hash || c.squote || c.dquote) begin
            // word ends, delimiter starts over as between tokens
            if (held_valid) begin
              res[cnt[0]] = mk(K_WORD, held_char, 1'b1, ERR_NONE);
              cnt = cnt + 2'd1;
            end
            if (st_v) begin
              res[cnt[0]] = st_r;
              cnt = cnt + 2'd1;
            end
            mode_next         = st_mode;
            token_length_next = st_len;
            held_valid_next   = st_held_v;
            held_char_next    = st_held_v ? b : 8'd0;
          end else begin
            if (held_valid) begin
              res[cnt[0]] = mk(K_WORD, held_char, 1'b0, ERR_NONE);
              cnt = cnt + 2'd1;
            end
            if (len_full) begin
              res[cnt[0]] = mk(K_WORD, b, 1'b1, ERR_LONG);
              cnt = cnt + 2'd1;
              mode_next         = M_IDLE;
              held_char_next    = '0;
              held_valid_next   = 1'b0;
              token_length_next = '0;
            end else begin
              token_length_next = len_inc;
              held_char_next    = b;
              held_valid_next   = 1'b1;
            end
          end
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      held_char    <= '0;
      held_valid   <= 1'b0;
      token_length <= '0;
    end else if (take) begin
      mode         <= mode_next;
      held_char    <= held_char_next;
      held_valid   <= held_valid_next;
      token_length <= token_length_next;
    end
  end

  // output register plus one spare slot for the second result of a byte
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (take) begin
      out_valid  <= (cnt != 2'd0) || (out_valid && !out_ready);
      pend_valid <= (cnt == 2'd2);
    end else if (pend_valid && out_free) begin
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cnt != 2'd0) begin
        out_res <= res[0];
      end
      pend <= res[1];
    end else if (pend_valid && out_free) begin
      out_res <= pend;
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("spare result held while output register is empty");

  a_err_ends_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.err != ERR_NONE) |-> out_res.last)
    else $error("error result not marked last");

  a_held_only_in_word: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (mode == M_WORD))
    else $error("held character outside a word");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    token_length < MAX_LEN)
    else $error("token length reached limit without ending token");

  a_end_follows_eot: assert property (@(posedge clk) disable iff (rst)
    (take && in_item.eot) |=> (mode == M_IDLE && !held_valid))
    else $error("scanner not idle after end of text");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// self-checking testbench for config_text_tokenizer_core
// depends on ctt_pkg and the tokenizer rtl; predicts every token transfer in a class
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  // scanner states of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_COMMENT,
    SCAN_CHAR_OPEN,
    SCAN_CHAR_ESC,
    SCAN_CHAR_CLOSE,
    SCAN_STRING,
    SCAN_STRING_ESC,
    SCAN_WORD
  } scan_t;

  // one text transfer: byte plus end-of-text mark
  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } text_item_t;

  // predicts token characters from accepted text and checks the token stream
  class token_board;
    scan_t      mode;
    logic [7:0] held;
    logic       held_v;
    logic [6:0] len;
    res_t       due[$];
    int         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    static function bit is_space(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    static function bit is_symbol(logic [7:0] b);
      return b == CH_LBRACE || b == CH_RBRACE || b == CH_COLON || b == CH_SEMI ||
             b == CH_PLUS || b == CH_EQUAL || b == CH_COMMA;
    endfunction

    static function bit is_delim(logic [7:0] b);
      return is_space(b) || is_symbol(b) || b == CH_HASH || b == CH_SQUOTE ||
             b == CH_DQUOTE;
    endfunction

    function void clear();
      mode   = SCAN_IDLE;
      held   = 8'h00;
      held_v = 1'b0;
      len    = '0;
    endfunction

    function void put(kind_t k, logic [7:0] c, logic l, err_t e);
      res_t r;
      r.kind = k;
      r.ch   = c;
      r.last = l;
      r.err  = e;
      due.push_back(r);
    endfunction

    // a byte seen between tokens
    function void open_token(logic [7:0] b);
      if (is_space(b)) begin
        mode = SCAN_IDLE;
      end else if (b == CH_HASH) begin
        mode = SCAN_COMMENT;
      end else if (is_symbol(b)) begin
        put(K_SYMBOL, b, 1'b1, ERR_NONE);
        mode = SCAN_IDLE;
      end else if (b == CH_SQUOTE) begin
        put(K_CHAR, CH_SQUOTE, 1'b0, ERR_NONE);
        mode = SCAN_CHAR_OPEN;
      end else if (b == CH_DQUOTE) begin
        put(K_STRING, CH_DQUOTE, 1'b0, ERR_NONE);
        len  = 7'd1;
        mode = SCAN_STRING;
      end else begin
        held   = b;
        held_v = 1'b1;
        len    = 7'd1;
        mode   = SCAN_WORD;
      end
    endfunction

    // one content byte of a string, the opening quote already counted
    function void string_byte(logic [7:0] b);
      len = len + 7'd1;
      if (len >= MAX_TOKEN_LEN_D) begin
        put(K_STRING, b, 1'b1, ERR_LONG);
        clear();
      end else begin
        put(K_STRING, b, 1'b0, ERR_NONE);
        mode = SCAN_STRING;
      end
    endfunction

    // note one accepted text transfer
    function void take_byte(logic [7:0] b, logic eot);
      if (eot) begin
        case (mode)
          SCAN_WORD: begin
            if (held_v) put(K_WORD, held, 1'b1, ERR_NONE);
          end
          SCAN_CHAR_OPEN, SCAN_CHAR_ESC, SCAN_CHAR_CLOSE: begin
            put(K_CHAR, 8'h00, 1'b1, ERR_CHAR);
          end
          SCAN_STRING, SCAN_STRING_ESC: begin
            put(K_STRING, 8'h00, 1'b1, ERR_STRING);
          end
          default: ;
        endcase
        put(K_END, 8'h00, 1'b1, ERR_NONE);
        clear();
        return;
      end
      case (mode)
        SCAN_IDLE: open_token(b);
        SCAN_COMMENT: begin
          if (b == CH_LF || b == CH_CR) mode = SCAN_IDLE;
        end
        SCAN_CHAR_OPEN: begin
          if (b == CH_BSLASH) begin
            mode = SCAN_CHAR_ESC;
          end else begin
            put(K_CHAR, b, 1'b0, ERR_NONE);
            mode = SCAN_CHAR_CLOSE;
          end
        end
        SCAN_CHAR_ESC: begin
          put(K_CHAR, b, 1'b0, ERR_NONE);
          mode = SCAN_CHAR_CLOSE;
        end
        SCAN_CHAR_CLOSE: begin
          if (b == CH_SQUOTE) put(K_CHAR, CH_SQUOTE, 1'b1, ERR_NONE);
          else put(K_CHAR, b, 1'b1, ERR_CHAR);
          clear();
        end
        SCAN_STRING: begin
          if (b == CH_DQUOTE) begin
            put(K_STRING, CH_DQUOTE, 1'b1, ERR_NONE);
            clear();
          end else if (b == CH_BSLASH) begin
            mode = SCAN_STRING_ESC;
          end else begin
            string_byte(b);
          end
        end
        SCAN_STRING_ESC: string_byte(b);
        default: begin
          if (is_delim(b)) begin
            if (held_v) put(K_WORD, held, 1'b1, ERR_NONE);
            clear();
            open_token(b);
          end else begin
            if (held_v) put(K_WORD, held, 1'b0, ERR_NONE);
            len = len + 7'd1;
            if (len >= MAX_TOKEN_LEN_D) begin
              put(K_WORD, b, 1'b1, ERR_LONG);
              clear();
            end else begin
              held   = b;
              held_v = 1'b1;
            end
          end
        end
      endcase
    endfunction

    // compare one token transfer against the oldest prediction
    function void check_token(logic [2:0] kind, logic [7:0] ch, logic last,
                              logic [1:0] err, logic [5:0] pad);
      res_t want;
      if (due.size() == 0) begin
        $error("token transfer with nothing predicted: kind %0d char %02h", kind, ch);
        errors++;
        return;
      end
      want = due.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind mismatch: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (ch !== want.ch) begin
        $error("token_char mismatch: expected %02h, actual %02h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("token_last mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
      if (err !== want.err) begin
        $error("error_code mismatch: expected %0d, actual %0d", want.err, err);
        errors++;
      end
      if (pad !== 6'd0) begin
        $error("tdata padding mismatch: expected 0, actual %0h", pad);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 250;   // long receiver hold-off for back-pressure

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  token_board  board = new();
  text_item_t  text_q[$];   // text waiting to be offered
  int          send_idle;   // percent of cycles the sender stays idle
  int          recv_stall;  // percent of cycles the receiver stalls
  bit          hold_req;    // asks the receiver for one long hold-off
  int          quiet_cnt = 0;

  config_text_tokenizer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] text_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] token_char, [9:8] error_code, rest zero
    .m_axis_tuser  (m_axis_tuser),   // [2:0] token_kind
    .m_axis_tlast  (m_axis_tlast)    // token_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic e);
    text_item_t it;
    it.b = b;
    it.e = e;
    text_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // end of text carries a random byte that the block must ignore
  task automatic push_eot();
    push_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // bare word of len bytes, none of them a delimiter
  task automatic push_word(input int len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      do c = 8'($urandom_range(255)); while (token_board::is_delim(c));
      push_byte(c, 1'b0);
    end
  endtask

  // string of len content characters, some escaped; closed only if asked
  task automatic push_string(input int len, input bit close);
    logic [7:0] c;
    push_byte(CH_DQUOTE, 1'b0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 15) begin
        push_byte(CH_BSLASH, 1'b0);
        push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        do c = 8'($urandom_range(255)); while (c == CH_DQUOTE || c == CH_BSLASH);
        push_byte(c, 1'b0);
      end
    end
    if (close) push_byte(CH_DQUOTE, 1'b0);
  endtask

  // one mostly well-formed piece of config text
  task automatic push_fragment();
    logic [7:0] spaces [4];
    logic [7:0] symbols [7];
    logic [7:0] c;
    int         r;
    int         n;
    spaces  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    symbols = '{CH_LBRACE, CH_RBRACE, CH_COLON, CH_SEMI, CH_PLUS, CH_EQUAL, CH_COMMA};
    r = $urandom_range(99);
    if (r < 8) begin
      push_byte(spaces[$urandom_range(3)], 1'b0);
    end else if (r < 20) begin
      push_byte(symbols[$urandom_range(6)], 1'b0);
    end else if (r < 28) begin
      // comment up to a line end
      push_byte(CH_HASH, 1'b0);
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR);
        push_byte(c, 1'b0);
      end
      push_byte($urandom_range(1) ? CH_LF : CH_CR, 1'b0);
    end else if (r < 42) begin
      // char literal, sometimes escaped, sometimes left unclosed
      push_byte(CH_SQUOTE, 1'b0);
      if ($urandom_range(9) == 0) push_byte(CH_BSLASH, 1'b0);
      push_byte(8'($urandom_range(255)), 1'b0);
      if ($urandom_range(99) < 85) push_byte(CH_SQUOTE, 1'b0);
      else push_byte(8'($urandom_range(255)), 1'b0);
    end else if (r < 60) begin
      n = ($urandom_range(99) < 8) ? $urandom_range(60, 70) : $urandom_range(8);
      push_string(n, $urandom_range(9) != 0);
    end else if (r < 88) begin
      n = ($urandom_range(99) < 8) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      push_word(n);
    end else if (r < 92) begin
      push_eot();
    end else begin
      push_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic gen_random(input int n);
    while (text_q.size() < n) push_fragment();
    push_eot();
  endtask

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // offer queued text one transfer at a time, with random idle gaps
  task automatic send_text();
    text_item_t it;
    while (text_q.size() != 0) begin
      it = text_q.pop_front();
      while ($urandom_range(99) < send_idle) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.b;
      s_axis_tlast  <= it.e;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      board.take_byte(it.b, it.e);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // wait until every predicted token has come out, then let the pipe settle
  task automatic drain();
    while (board.due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    gen_random(n);
    send_text();
    drain();
  endtask

  // token receiver: checks each transfer and picks tready for the next cycle
  initial begin
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        board.check_token(m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast,
                          m_axis_tdata[9:8], m_axis_tdata[15:10]);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("config_text_tokenizer_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    send_idle     = 0;
    recv_stall    = 0;
    hold_req      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: symbols, word ended by a symbol, literals, escapes, comment
    push_text("{ }:;+=,");
    push_text("ab=");
    push_text("'x'");
    push_text("'\\''");
    push_text("'''");
    push_text("'ab");          // unclosed literal
    push_text("\"a\\\"\"");    // string with escaped quote
    push_text("# c\n");
    push_byte(8'h00, 1'b0);    // extreme bytes as word characters
    push_byte(8'hff, 1'b0);
    push_eot();                // end flushes the pending word
    push_text("'");  push_eot();
    push_text("'\\"); push_eot();
    push_text("'z"); push_eot();
    push_text("\"q"); push_eot();
    push_text("\"\\"); push_eot();
    push_text("#x"); push_eot();
    push_eot();
    send_text();
    drain();

    // back-pressure: receiver holds off while long tokens keep coming
    hold_req = 1'b1;
    push_word(MAX_TOKEN_LEN_D);      // word reaches the length limit
    push_byte(CH_SPACE, 1'b0);
    push_string(MAX_TOKEN_LEN_D, 1'b1);  // string reaches the length limit
    run_phase(200, 0, 0);

    run_phase(75, 0, 0);
    run_phase(75, 82, 0);
    run_phase(75, 0, 82);
    run_phase(75, 28, 28);

    if (board.errors == 0)
      $display("config_text_tokenizer_core test passed");
    else
      $display("config_text_tokenizer_core test failed");
    $finish;
  end

endmodule

`default_nettype wire
